FILE: sv/rgbyc_pkg.sv
// Package: widths, payload structs, register indexes and divider helpers for the converter.
package rgbyc_pkg;

  localparam int OUT_BITS = 12;
  localparam int CH_W     = 16;
  localparam int SUM_W    = 34;                    // coefficient-weighted channel sum
  localparam int REM_W    = SUM_W + OUT_BITS + 1;  // scaled numerator / remainder
  localparam int LANES    = 4;
  localparam logic [OUT_BITS-1:0] OMAX = {OUT_BITS{1'b1}};

  localparam int LANE_LUMA  = 0;
  localparam int LANE_CB    = 1;
  localparam int LANE_CR    = 2;
  localparam int LANE_ALPHA = 3;

  localparam logic [4:0]  DEPTH_RESET = 5'd8;
  localparam logic [15:0] KR_RESET    = 16'd13936;
  localparam logic [15:0] KG_RESET    = 16'd46868;
  localparam logic [15:0] KB_RESET    = 16'd4733;

  typedef enum logic [1:0] {
    CFG_SAMPLE_BITS = 2'd0,
    CFG_COEFF_RED   = 2'd1,
    CFG_COEFF_GREEN = 2'd2,
    CFG_COEFF_BLUE  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pix_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] luma;
    logic [OUT_BITS-1:0] chroma_blue;
    logic [OUT_BITS-1:0] chroma_red;
    logic [OUT_BITS-1:0] alpha_out;
  } pix_out_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [SUM_W-1:0]    den;
    logic [OUT_BITS-1:0] quo;
    logic                fixed;   // result already known, cells pass it along
  } div_lane_t;

  typedef struct packed {
    div_lane_t [LANES-1:0] lane;
  } div_beat_t;

  // Sets up floor(OMAX*num/den), saturated when the quotient needs more than OUT_BITS.
  function automatic div_lane_t div_prep(logic [SUM_W-1:0] num, logic [SUM_W-1:0] den);
    div_lane_t        l;
    logic [REM_W-1:0] num_x;
    logic [REM_W-1:0] den_x;
    num_x   = {{(REM_W-SUM_W){1'b0}}, num};
    den_x   = {{(REM_W-SUM_W){1'b0}}, den};
    l.rem   = (num_x << OUT_BITS) - num_x;
    l.den   = den;
    l.fixed = (l.rem >= (den_x << OUT_BITS));
    l.quo   = l.fixed ? OMAX : '0;
    return l;
  endfunction

endpackage

FILE: sv/rgbyc_front.sv
// Front end: products, weighted sum, chroma numerators and divider setup, three stages.
module rgbyc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rgbyc_pkg::pix_in_t       in_pix,
  input  logic [4:0]               sample_bits,
  input  logic [15:0]              coeff_red,
  input  logic [15:0]              coeff_green,
  input  logic [15:0]              coeff_blue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rgbyc_pkg::div_beat_t     out_beat
);

  // stage 1
  logic        v1_r;
  logic [31:0] pr_r, pg_r, pb_r, tr_r, tb_r;
  logic [15:0] m_r, r1_r, b1_r, a1_r;
  // stage 2
  logic        v2_r;
  logic [33:0] s_r, db_r, dr_r;
  logic [35:0] nb_r, nr_r;
  logic [31:0] lden_r;
  logic [15:0] m2_r, a2_r;
  // stage 3
  logic        v3_r;
  rgbyc_pkg::div_beat_t beat_r;

  logic        rdy1, rdy2, rdy3;
  logic [4:0]  depth;
  logic [16:0] m_wide;
  logic [15:0] m_nxt;
  logic [33:0] s_nxt, posb, posr;
  logic [35:0] nb_nxt, nr_nxt;
  rgbyc_pkg::div_beat_t beat_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    depth = sample_bits;
    if (sample_bits < 5'd8) depth = 5'd8;
    if (sample_bits > 5'd16) depth = 5'd16;
    m_wide = (17'd1 << depth) - 17'd1;
    m_nxt  = m_wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      pr_r <= coeff_red * in_pix.red;
      pg_r <= coeff_green * in_pix.green;
      pb_r <= coeff_blue * in_pix.blue;
      tr_r <= m_nxt * (16'hFFFF - coeff_red);
      tb_r <= m_nxt * (16'hFFFF - coeff_blue);
      m_r  <= m_nxt;
      r1_r <= in_pix.red;
      b1_r <= in_pix.blue;
      a1_r <= in_pix.alpha;
    end
  end

  always_comb begin
    s_nxt  = {2'b0, pr_r} + {2'b0, pg_r} + {2'b0, pb_r};
    posb   = {2'b0, b1_r, 16'b0} - {18'b0, b1_r} + {2'b0, tb_r};
    posr   = {2'b0, r1_r, 16'b0} - {18'b0, r1_r} + {2'b0, tr_r};
    nb_nxt = {2'b0, posb} - {2'b0, s_nxt};
    nr_nxt = {2'b0, posr} - {2'b0, s_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      s_r    <= s_nxt;
      nb_r   <= nb_nxt;
      nr_r   <= nr_nxt;
      db_r   <= {1'b0, tb_r, 1'b0};
      dr_r   <= {1'b0, tr_r, 1'b0};
      lden_r <= {m_r, 16'b0} - {16'b0, m_r};
      m2_r   <= m_r;
      a2_r   <= a1_r;
    end
  end

  // chroma: non-positive numerator gives zero, one at or past the span saturates
  function automatic rgbyc_pkg::div_lane_t chroma_prep(logic [35:0] n, logic [33:0] d);
    rgbyc_pkg::div_lane_t l;
    l = rgbyc_pkg::div_prep(n[33:0], d);
    if (n[35] || n == '0) begin
      l.fixed = 1'b1;
      l.quo   = '0;
    end else if (n[34:0] >= {1'b0, d}) begin
      l.fixed = 1'b1;
      l.quo   = rgbyc_pkg::OMAX;
    end
    return l;
  endfunction

  always_comb begin
    beat_nxt.lane[rgbyc_pkg::LANE_LUMA]  = rgbyc_pkg::div_prep(s_r, {2'b0, lden_r});
    beat_nxt.lane[rgbyc_pkg::LANE_CB]    = chroma_prep(nb_r, db_r);
    beat_nxt.lane[rgbyc_pkg::LANE_CR]    = chroma_prep(nr_r, dr_r);
    beat_nxt.lane[rgbyc_pkg::LANE_ALPHA] =
      rgbyc_pkg::div_prep({18'b0, a2_r}, {18'b0, m2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
    if (rdy3 && v2_r) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_beat  = beat_r;

endmodule

FILE: sv/rgbyc_div_cell.sv
// Divider cell: settles one quotient bit of all four lanes and hands the beat on.
module rgbyc_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  rgbyc_pkg::div_beat_t  up_beat,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output rgbyc_pkg::div_beat_t  dn_beat
);

  logic                 v_r;
  rgbyc_pkg::div_beat_t beat_r;
  rgbyc_pkg::div_beat_t beat_nxt;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    logic [rgbyc_pkg::REM_W-1:0] den_sh;
    logic [rgbyc_pkg::REM_W:0]   trial;
    beat_nxt = up_beat;
    for (int i = 0; i < rgbyc_pkg::LANES; i++) begin
      den_sh = {{(rgbyc_pkg::REM_W-rgbyc_pkg::SUM_W){1'b0}}, up_beat.lane[i].den} << SHIFT;
      trial  = {1'b0, up_beat.lane[i].rem} - {1'b0, den_sh};
      if (!up_beat.lane[i].fixed && !trial[rgbyc_pkg::REM_W]) begin
        beat_nxt.lane[i].rem        = trial[rgbyc_pkg::REM_W-1:0];
        beat_nxt.lane[i].quo[SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_beat  = beat_r;

endmodule

FILE: sv/rgb_to_ycbcr_convert.sv
// Top level: RGBA to full-range YCbCr plus alpha converter.
//
// Input channel: in_valid / in_stall / in_data carry one RGBA pixel per beat,
// channels at the depth set by sample_bits (8..16, values outside are clamped).
// Output channel: out_valid / out_stall / out_data carry luma, Cb, Cr and
// alpha, each 12 bits, floored and saturated.
// Config port: cfg_we writes cfg_data into the register at cfg_index
// (0 sample_bits, 1 coeff_red, 2 coeff_green, 3 coeff_blue); write only idle.
//
// Structure: 15 register stages, three front stages (multiply, sum, divider
// setup) then a row of 12 divider cells, one quotient bit per cell, with
// every lane of a pixel moving through the row together. Throughput is one
// pixel per clock while the receiver does not stall; every stage holds one beat.
// When the receiver stalls, the last cell holds its beat and upstream stages
// keep filling empty slots; in_stall rises only when every stage is full.
// Reset (synchronous, rst_n low) empties the pipe and restores the
// BT.709-style default weights and 8-bit depth.
module rgb_to_ycbcr_convert (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbyc_pkg::pix_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbyc_pkg::pix_out_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int NB = rgbyc_pkg::OUT_BITS;

  logic [4:0]  sample_bits_r;
  logic [15:0] coeff_red_r, coeff_green_r, coeff_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_bits_r <= rgbyc_pkg::DEPTH_RESET;
      coeff_red_r   <= rgbyc_pkg::KR_RESET;
      coeff_green_r <= rgbyc_pkg::KG_RESET;
      coeff_blue_r  <= rgbyc_pkg::KB_RESET;
    end else if (cfg_we) begin
      case (rgbyc_pkg::cfg_index_t'(cfg_index))
        rgbyc_pkg::CFG_SAMPLE_BITS: sample_bits_r <= cfg_data[4:0];
        rgbyc_pkg::CFG_COEFF_RED:   coeff_red_r   <= cfg_data;
        rgbyc_pkg::CFG_COEFF_GREEN: coeff_green_r <= cfg_data;
        rgbyc_pkg::CFG_COEFF_BLUE:  coeff_blue_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell chain: index 0 is the front output, index NB the last cell
  logic                 vld [NB+1];
  logic                 rdy [NB+1];
  rgbyc_pkg::div_beat_t beat [NB+1];
  logic                 in_ready;

  rgbyc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pix     (in_data),
    .sample_bits(sample_bits_r),
    .coeff_red  (coeff_red_r),
    .coeff_green(coeff_green_r),
    .coeff_blue (coeff_blue_r),
    .out_valid  (vld[0]),
    .out_ready  (rdy[0]),
    .out_beat   (beat[0])
  );

  for (genvar k = 0; k < NB; k++) begin : g_cell
    rgbyc_div_cell #(.SHIFT(NB - 1 - k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(vld[k]),
      .up_ready(rdy[k]),
      .up_beat (beat[k]),
      .dn_valid(vld[k+1]),
      .dn_ready(rdy[k+1]),
      .dn_beat (beat[k+1])
    );
  end

  assign rdy[NB]   = !out_stall;
  assign in_stall  = !in_ready;
  assign out_valid = vld[NB];

  assign out_data.luma        = beat[NB].lane[rgbyc_pkg::LANE_LUMA].quo;
  assign out_data.chroma_blue = beat[NB].lane[rgbyc_pkg::LANE_CB].quo;
  assign out_data.chroma_red  = beat[NB].lane[rgbyc_pkg::LANE_CR].quo;
  assign out_data.alpha_out   = beat[NB].lane[rgbyc_pkg::LANE_ALPHA].quo;

endmodule

FILE: sv/rgbyc_checker.sv
// Port checker for the converter, bound to the top level.
module rgbyc_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_stall,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rgbyc_pkg::pix_out_t  out_data
);

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // input backs up only when the whole pipe is full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipe has room");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result beat dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind rgb_to_ycbcr_convert rgbyc_checker u_rgbyc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
